// ----- rtl/pump_relay_lockout_controller_assert.svh -----
// Assertion macros used by the pump relay lockout controller checker.
`ifndef PUMP_RELAY_LOCKOUT_CONTROLLER_ASSERT_SVH
`define PUMP_RELAY_LOCKOUT_CONTROLLER_ASSERT_SVH

// Clocked check that is ignored while reset is asserted.
`define PRLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PRLC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/prlc_pkg.sv -----
// Types and constants for the pump relay lockout controller.
`default_nettype none

package prlc_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_REST_PERIOD   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_BUZZER        = 2'd2;

  localparam logic [15:0] REST_PERIOD_RST   = 16'd10000;
  localparam logic [9:0]  SAMPLE_PERIOD_RST = 10'd50;
  localparam logic [15:0] BUZZER_RST        = 16'd200;
  localparam logic [9:0]  MS_PER_SECOND     = 10'd1000;

  // Command codes.
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_EMERGENCY = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  // Start outcome codes.
  localparam logic [2:0] OUT_NONE    = 3'd0;
  localparam logic [2:0] OUT_STARTED = 3'd1;
  localparam logic [2:0] OUT_LOCKED  = 3'd2;
  localparam logic [2:0] OUT_RESTING = 3'd3;
  localparam logic [2:0] OUT_UNSAFE  = 3'd4;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_LOCKED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] rest_period_ms;
    logic [9:0]  sample_period_ms;
    logic [15:0] buzzer_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       emergency_level;
    logic       manual_level;
    logic       safe_to_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pump_state;
    logic        relay_on;
    logic        buzzer_on;
    logic [2:0]  start_outcome;
    logic [31:0] run_seconds;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] ms_since_change;
    logic        changed_once;
    logic [9:0]  ms_since_sample;
    logic        prev_emer;
    logic        prev_man;
    logic [9:0]  run_ms_frac;
    logic [31:0] run_secs;
    logic [15:0] buzzer_left;
  } pump_state_t;

endpackage

`default_nettype wire

// ----- rtl/prlc_ifs.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface prlc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       emergency_level;
  logic       manual_level;
  logic       safe_to_start;

  modport source (output valid, cmd, emergency_level, manual_level, safe_to_start,
                  input ready);
  modport sink (input valid, cmd, emergency_level, manual_level, safe_to_start,
                output ready);
endinterface

interface prlc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  pump_state;
  logic        relay_on;
  logic        buzzer_on;
  logic [2:0]  start_outcome;
  logic [31:0] run_seconds;

  modport source (output valid, pump_state, relay_on, buzzer_on, start_outcome,
                  run_seconds, input ready);
  modport sink (input valid, pump_state, relay_on, buzzer_on, start_outcome,
                run_seconds, output ready);
endinterface

`default_nettype wire

// ----- rtl/prlc_cfg_regs.sv -----
// APB configuration registers: rest period, sample period and buzzer length.
`default_nettype none

module prlc_cfg_regs
  import prlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_period_ms   <= REST_PERIOD_RST;
      cfg_r.sample_period_ms <= SAMPLE_PERIOD_RST;
      cfg_r.buzzer_ms        <= BUZZER_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_REST_PERIOD:   cfg_r.rest_period_ms   <= pwdata[15:0];
        REG_SAMPLE_PERIOD: cfg_r.sample_period_ms <= pwdata[9:0];
        REG_BUZZER:        cfg_r.buzzer_ms        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REST_PERIOD:   prdata = {16'd0, cfg_r.rest_period_ms};
      REG_SAMPLE_PERIOD: prdata = {22'd0, cfg_r.sample_period_ms};
      REG_BUZZER:        prdata = {16'd0, cfg_r.buzzer_ms};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/prlc_core.sv -----
// Controller state and the combinational update that one item applies to it.
`default_nettype none

module prlc_core
  import prlc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  pump_state_t st_r;
  pump_state_t st_nxt;
  logic [2:0]  outcome;
  logic        start_req;
  logic        sample_hit;
  logic [9:0]  frac_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode            <= MODE_STOPPED;
      st_r.ms_since_change <= '0;
      st_r.changed_once    <= 1'b0;
      st_r.ms_since_sample <= '0;
      st_r.prev_emer       <= 1'b1;
      st_r.prev_man        <= 1'b1;
      st_r.run_ms_frac     <= '0;
      st_r.run_secs        <= '0;
      st_r.buzzer_left     <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  // Next state. A start attempt, from a command or from a manual button
  // edge, is always the last action of an item, so it is resolved once at
  // the end against the state the earlier actions left.
  always_comb begin
    st_nxt     = st_r;
    outcome    = OUT_NONE;
    start_req  = 1'b0;
    sample_hit = 1'b0;
    frac_inc   = st_r.run_ms_frac + 10'd1;

    case (item.cmd)
      CMD_TICK: begin
        if (st_r.ms_since_change != 16'hFFFF) begin
          st_nxt.ms_since_change = st_r.ms_since_change + 16'd1;
        end
        if (st_r.ms_since_sample != 10'h3FF) begin
          st_nxt.ms_since_sample = st_r.ms_since_sample + 10'd1;
        end
        if (st_r.buzzer_left != 16'd0) begin
          st_nxt.buzzer_left = st_r.buzzer_left - 16'd1;
        end
        if (st_r.mode == MODE_RUNNING) begin
          if (frac_inc >= MS_PER_SECOND) begin
            st_nxt.run_ms_frac = '0;
            if (st_r.run_secs != 32'hFFFF_FFFF) begin
              st_nxt.run_secs = st_r.run_secs + 32'd1;
            end
          end else begin
            st_nxt.run_ms_frac = frac_inc;
          end
        end

        sample_hit = (st_nxt.ms_since_sample >= cfg.sample_period_ms);
        if (sample_hit) begin
          st_nxt.ms_since_sample = '0;
          // Emergency edge is handled before the manual edge.
          if (!item.emergency_level && st_r.prev_emer) begin
            st_nxt.mode            = MODE_LOCKED;
            st_nxt.run_ms_frac     = '0;
            st_nxt.run_secs        = '0;
            st_nxt.buzzer_left     = cfg.buzzer_ms;
            st_nxt.ms_since_change = '0;
            st_nxt.changed_once    = 1'b1;
          end
          st_nxt.prev_emer = item.emergency_level;
          if (!item.manual_level && st_r.prev_man) begin
            if (st_nxt.mode == MODE_RUNNING) begin
              st_nxt.mode            = MODE_STOPPED;
              st_nxt.run_ms_frac     = '0;
              st_nxt.run_secs        = '0;
              st_nxt.ms_since_change = '0;
              st_nxt.changed_once    = 1'b1;
            end else begin
              start_req = 1'b1;
            end
          end
          st_nxt.prev_man = item.manual_level;
        end
      end
      CMD_START: begin
        start_req = 1'b1;
      end
      CMD_STOP: begin
        if (st_r.mode != MODE_STOPPED) begin
          st_nxt.mode            = MODE_STOPPED;
          st_nxt.run_ms_frac     = '0;
          st_nxt.run_secs        = '0;
          st_nxt.ms_since_change = '0;
          st_nxt.changed_once    = 1'b1;
        end
      end
      CMD_EMERGENCY: begin
        st_nxt.mode            = MODE_LOCKED;
        st_nxt.run_ms_frac     = '0;
        st_nxt.run_secs        = '0;
        st_nxt.buzzer_left     = cfg.buzzer_ms;
        st_nxt.ms_since_change = '0;
        st_nxt.changed_once    = 1'b1;
      end
      CMD_CLEAR: begin
        if (st_r.mode == MODE_LOCKED) begin
          st_nxt.mode            = MODE_STOPPED;
          st_nxt.ms_since_change = '0;
          st_nxt.changed_once    = 1'b1;
        end
      end
      default: ;
    endcase

    if (start_req) begin
      if (st_nxt.mode == MODE_LOCKED) begin
        outcome = OUT_LOCKED;
      end else if (st_nxt.changed_once &&
                   (st_nxt.ms_since_change < cfg.rest_period_ms)) begin
        outcome = OUT_RESTING;
      end else if (!item.safe_to_start) begin
        outcome = OUT_UNSAFE;
      end else begin
        outcome                = OUT_STARTED;
        st_nxt.mode            = MODE_RUNNING;
        st_nxt.run_ms_frac     = '0;
        st_nxt.run_secs        = '0;
        st_nxt.ms_since_change = '0;
        st_nxt.changed_once    = 1'b1;
      end
    end
  end

  // Result fields follow from the state the item leaves.
  always_comb begin
    result.pump_state    = st_nxt.mode;
    result.relay_on      = (st_nxt.mode == MODE_RUNNING);
    result.buzzer_on     = (st_nxt.buzzer_left != 16'd0);
    result.start_outcome = outcome;
    result.run_seconds   = (st_nxt.mode == MODE_RUNNING) ? st_nxt.run_secs : 32'd0;
  end

endmodule

`default_nettype wire

// ----- rtl/pump_relay_lockout_controller.sv -----
// Top level of the pump relay lockout controller.
//
//   Channel   Direction  Handshake           Carries
//   in_chan   sink       valid/ready         cmd, button levels, safe_to_start
//   out_chan  source     valid/ready         pump state, relay, buzzer, outcome,
//                                            run seconds
//   APB       slave      psel/penable/pready rest, sample and buzzer registers
//
// An item is registered in the input register at its transfer and its result is
// registered in the output register when prlc_core takes its step.
// The state update in prlc_core sets the throughput, one item per clock while
// out_chan does not stall. When it stalls, the input register holds its item
// and in_chan.ready drops only while both registers are full.
// Reset is synchronous and active low; it restores the register defaults.
`default_nettype none

module pump_relay_lockout_controller
  import prlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  prlc_in_if.sink                    in_chan,
  prlc_out_if.source                 out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t      cfg;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t step_result;
  logic      stall;
  logic      step_en;
  logic      in_xfer;

  prlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prlc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  assign stall         = out_valid_r && !out_chan.ready;
  assign step_en       = s1_valid_r && !stall;
  assign in_chan.ready = !s1_valid_r || !stall;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step_en) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.cmd             <= in_chan.cmd;
      s1_item_r.emergency_level <= in_chan.emergency_level;
      s1_item_r.manual_level    <= in_chan.manual_level;
      s1_item_r.safe_to_start   <= in_chan.safe_to_start;
    end
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pump_state    = out_item_r.pump_state;
  assign out_chan.relay_on      = out_item_r.relay_on;
  assign out_chan.buzzer_on     = out_item_r.buzzer_on;
  assign out_chan.start_outcome = out_item_r.start_outcome;
  assign out_chan.run_seconds   = out_item_r.run_seconds;

endmodule

`default_nettype wire

// ----- rtl/prlc_checker.sv -----
// Port-level checks for the pump relay lockout controller and their binding.
`default_nettype none

`include "pump_relay_lockout_controller_assert.svh"

module prlc_checker
  import prlc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  pump_state,
  input wire logic        relay_on,
  input wire logic [2:0]  start_outcome,
  input wire logic [31:0] run_seconds
);

  `PRLC_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `PRLC_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `PRLC_ASSERT(a_relay_matches, out_valid |-> (relay_on == (pump_state == MODE_RUNNING)), "relay disagrees with state")
  `PRLC_ASSERT(a_secs_only_running, out_valid && (run_seconds != 32'd0) |-> relay_on, "run time shown while not running")
  `PRLC_ASSERT(a_start_runs, out_valid && (start_outcome == OUT_STARTED) |-> (pump_state == MODE_RUNNING), "start accepted but pump not running")

endmodule

bind pump_relay_lockout_controller prlc_checker u_prlc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .pump_state    (out_chan.pump_state),
  .relay_on      (out_chan.relay_on),
  .start_outcome (out_chan.start_outcome),
  .run_seconds   (out_chan.run_seconds)
);

`default_nettype wire
